>>> design/iwo_pkg.sv
// ----------------------------------------------------------------------------
// iwo_pkg
// Shared types and constants for the interpolating wavetable oscillator:
// operation codes, register indexes, controller states and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package iwo_pkg;

	localparam int PHASE_BITS  = 32;
	localparam int WEIGHT_BITS = 16;
	localparam int INC_BITS    = 31;
	localparam int AMP_BITS    = 15;
	localparam int CFG_BITS    = 31;
	localparam int CFG_IDX_BITS = 1;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_TICK  = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_PHASE_INC = 1'b0,
		REG_AMPLITUDE = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BLEND,
		ST_SCALE
	} state_t;

	typedef struct packed {
		logic table_wr;
		logic tick_start;
		logic blend_en;
		logic result_load;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

endpackage

>>> design/iwo_ctrl.sv
// ----------------------------------------------------------------------------
// iwo_ctrl
// Controller state machine: accepts transactions, sequences the table read,
// the blend multiply and the amplitude multiply, and loads the output.
// ----------------------------------------------------------------------------
module iwo_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            op,
	input  iwo_pkg::status_t status,
	output iwo_pkg::cmd_t   cmd
);
	import iwo_pkg::*;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (op == OP_TICK) begin
						cmd.tick_start = 1'b1;
						state_next     = ST_BLEND;
					end else begin
						cmd.table_wr = 1'b1;
					end
				end
			end
			ST_BLEND: begin
				cmd.blend_en = 1'b1;
				state_next   = ST_SCALE;
			end
			ST_SCALE: begin
				if (status.out_free) begin
					cmd.result_load = 1'b1;
					state_next      = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

endmodule

>>> design/iwo_datapath.sv
// ----------------------------------------------------------------------------
// iwo_datapath
// Phase accumulator, wavetable memory, blend and amplitude multipliers,
// configuration registers and the output register.
// ----------------------------------------------------------------------------
module iwo_datapath #(
	parameter int INDEX_BITS  = 8,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  iwo_pkg::cmd_t                          cmd,
	output iwo_pkg::status_t                       status,
	input  logic                                   cfg_wr_en,
	input  logic [iwo_pkg::CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [iwo_pkg::CFG_BITS-1:0]           cfg_data,
	input  logic [INDEX_BITS:0]                    table_addr,
	input  logic signed [SAMPLE_BITS-1:0]          table_value,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [SAMPLE_BITS-1:0]          sample
);
	import iwo_pkg::*;

	localparam int ADDR_W   = INDEX_BITS + 1;
	localparam int DEPTH    = (1 << INDEX_BITS) + 1;
	localparam int DIFF_W   = SAMPLE_BITS + 1;
	localparam int BLEND_W  = SAMPLE_BITS + 18;
	localparam int SCALED_W = BLEND_W + AMP_BITS + 1;
	localparam int SHIFT    = 16;

	logic [INC_BITS-1:0]   inc_q;
	logic [AMP_BITS-1:0]   amp_q;
	logic [PHASE_BITS-1:0] phase_q;
	logic                  was_silent_q;

	logic signed [SAMPLE_BITS-1:0] table_mem [DEPTH];

	logic signed [SAMPLE_BITS-1:0] e0_s1;
	logic signed [SAMPLE_BITS-1:0] e1_s1;
	logic [WEIGHT_BITS-1:0]        w_s1;
	logic                          silent_s1;
	logic signed [BLEND_W-1:0]     blend_s2;
	logic                          silent_s2;

	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;

	logic                          silent;
	logic [PHASE_BITS-1:0]         phase_eff;
	logic [ADDR_W-1:0]             rd_idx0;
	logic [ADDR_W-1:0]             rd_idx1;
	logic [WEIGHT_BITS-1:0]        weight;
	logic signed [DIFF_W-1:0]      diff;
	logic signed [BLEND_W-1:0]     diff_term;
	logic signed [BLEND_W-1:0]     base;
	logic signed [SCALED_W-1:0]    scaled;

	assign silent    = (amp_q == '0);
	assign phase_eff = was_silent_q ? '0 : phase_q;
	assign rd_idx0   = {1'b0, phase_eff[PHASE_BITS-1 -: INDEX_BITS]};
	assign rd_idx1   = rd_idx0 + ADDR_W'(1);
	assign weight    = phase_eff[PHASE_BITS-1-INDEX_BITS -: WEIGHT_BITS];

	assign diff      = $signed({e1_s1[SAMPLE_BITS-1], e1_s1})
	                 - $signed({e0_s1[SAMPLE_BITS-1], e0_s1});
	assign diff_term = diff * $signed({1'b0, w_s1});
	assign base      = $signed({{(BLEND_W-SAMPLE_BITS-SHIFT){e0_s1[SAMPLE_BITS-1]}},
	                            e0_s1, {SHIFT{1'b0}}});
	assign scaled    = blend_s2 * $signed({1'b0, amp_q});

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_q <= '0;
			amp_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_PHASE_INC: inc_q <= cfg_data[INC_BITS-1:0];
				REG_AMPLITUDE: amp_q <= cfg_data[AMP_BITS-1:0];
				default: ;
			endcase
		end
	end

	// phase accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= '0;
			was_silent_q <= 1'b1;
		end else if (cmd.tick_start) begin
			if (silent) begin
				phase_q      <= phase_q + {1'b0, inc_q};
				was_silent_q <= 1'b1;
			end else begin
				phase_q      <= phase_eff + {1'b0, inc_q};
				was_silent_q <= 1'b0;
			end
		end
	end

	// wavetable memory
	always_ff @(posedge clk) begin
		if (cmd.table_wr && (table_addr <= ADDR_W'(DEPTH - 1))) begin
			table_mem[table_addr] <= table_value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tick_start) begin
			e0_s1     <= table_mem[rd_idx0];
			e1_s1     <= table_mem[rd_idx1];
			w_s1      <= weight;
			silent_s1 <= silent;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.blend_en) begin
			blend_s2  <= base + diff_term;
			silent_s2 <= silent_s1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.result_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.result_load) begin
			sample_q <= silent_s2 ? '0 : scaled[2*SHIFT +: SAMPLE_BITS];
		end
	end

	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign sample          = sample_q;

endmodule

>>> design/interpolating_wavetable_oscillator_core.sv
// ----------------------------------------------------------------------------
// interpolating_wavetable_oscillator_core
// Phase-accumulator oscillator with a linearly interpolated wavetable.
// ----------------------------------------------------------------------------
// A write transaction (op = 0) stores one signed entry of the 2^INDEX_BITS+1
// entry wavetable in the cycle it is accepted and returns no result; a new
// transaction is taken on the next cycle. A tick transaction (op = 1) returns
// one sample and occupies the block until it is finished: the two wavetable
// reads, the interpolation multiply and the amplitude multiply run one after
// the other, and no new transaction is accepted until the sample is loaded. A
// finished sample waits in the output register while the next transaction
// is accepted; a tick stalls in its last step only if the previous sample
// has not been taken. With amplitude zero a tick returns zero and the next
// audible tick restarts the phase at zero. Entries must be written before
// a tick reads them.
module interpolating_wavetable_oscillator_core #(
	parameter int INDEX_BITS  = 8,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [iwo_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [iwo_pkg::CFG_BITS-1:0]      cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              op,
	input  logic [INDEX_BITS:0]               table_addr,
	input  logic signed [SAMPLE_BITS-1:0]     table_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [SAMPLE_BITS-1:0]     sample
);
	import iwo_pkg::*;

	cmd_t    cmd;
	status_t status;

	iwo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.status   (status),
		.cmd      (cmd)
	);

	iwo_datapath #(
		.INDEX_BITS  (INDEX_BITS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.table_addr  (table_addr),
		.table_value (table_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.sample      (sample)
	);

endmodule

>>> design/iwo_checker.sv
// ----------------------------------------------------------------------------
// iwo_checker
// Port-level checks for the wavetable oscillator, bound to the top level.
// ----------------------------------------------------------------------------
module iwo_checker #(
	parameter int SAMPLE_BITS = 16
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          op,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [SAMPLE_BITS-1:0] sample
);
	import iwo_pkg::*;

	// a table write never produces a result
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (op == OP_WRITE) && !out_valid |=> !out_valid)
		else $error("result appeared after a table write");

	// a tick holds off the next transaction
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (op == OP_TICK) |=> !in_ready)
		else $error("transaction accepted right after a tick");

	// a new result only follows a busy cycle
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without a tick in progress");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample))
		else $error("stalled result changed");

endmodule

bind interpolating_wavetable_oscillator_core iwo_checker #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_iwo_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.op        (op),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.sample    (sample)
);
